>>> rtl/pse_pkg.sv
// Shared types and constants for the postfix stack evaluator.
// Used by the top level and by the iterative divider; depends on nothing.
package pse_pkg;

  // Token codes carried by the op field.
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SUB    = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;
  localparam logic [2:0] OP_FINISH = 3'd5;

  // Status codes carried by the status field.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_DIVZERO = 3'd3;
  localparam logic [2:0] ST_SAT     = 3'd4;

  // Q16.16 values and the divider geometry.
  localparam int VAL_W  = 32;
  localparam int FRAC_W = 16;
  localparam int NUM_W  = VAL_W + FRAC_W;      // magnitude of left * 2^16
  localparam int DEN_W  = VAL_W;               // magnitude of right
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int WIDE_W = NUM_W + 1;           // signed width before saturation

  typedef struct packed {
    logic             sat;
    logic [VAL_W-1:0] value;
  } sat_res_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

>>> rtl/pse_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pse_pkg for the operand widths and the control struct.
module pse_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pse_pkg::NUM_W-1:0] num,
  input  logic [pse_pkg::DEN_W-1:0] den,
  output pse_pkg::div_ctrl_t        ctrl,
  output logic [pse_pkg::NUM_W-1:0] quo
);

  logic                      busy;
  logic                      done;
  logic [pse_pkg::CNT_W-1:0] count;
  logic [pse_pkg::DEN_W-1:0] rem;
  logic [pse_pkg::DEN_W-1:0] dsr;
  logic [pse_pkg::DEN_W:0]   rem_sh;
  logic [pse_pkg::DEN_W:0]   diff;

  // The dividend sits in quo and shifts out at the top as quotient bits come in.
  assign rem_sh = {rem, quo[pse_pkg::NUM_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= pse_pkg::CNT_W'(pse_pkg::NUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == pse_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      dsr <= den;
      rem <= '0;
    end else if (busy) begin
      if (!diff[pse_pkg::DEN_W]) begin
        rem <= diff[pse_pkg::DEN_W-1:0];
        quo <= {quo[pse_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[pse_pkg::DEN_W-1:0];
        quo <= {quo[pse_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  assign ctrl.start = start;
  assign ctrl.done  = done;

endmodule

>>> rtl/postfix_stack_evaluator.sv
// Postfix evaluator over a Q16.16 value stack held in a synchronous memory.
// Push, finish, underflow and overflow go from S_IDLE to S_DONE; add, subtract and
// divide by zero pass S_READ; multiply passes S_READ and S_MUL; divide passes S_READ
// and waits in S_DIV for the divider's 48 quotient bits, so it takes longest. One token
// is in flight at a time and the next is taken the cycle after its result is loaded.
// Reset empties the stack; stack memory contents are not cleared.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic signed [15:0] operand,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] top_value,
  output logic [6:0]         stack_depth,
  output logic [2:0]         status,
  output logic               answer_valid
);

  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int VW     = pse_pkg::VAL_W;
  localparam int WW     = pse_pkg::WIDE_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                 state;
  logic [SP_W-1:0]        sp;
  logic [SP_W-1:0]        new_sp;
  logic [VW-1:0]          top;
  logic [VW-1:0]          mem [STACK_DEPTH];
  logic [VW-1:0]          rd_data;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      wr_addr;
  logic                   wr_en;
  logic                   mem_we;
  logic [2:0]             op_q;
  logic [VW-1:0]          res_value;
  logic [2:0]             res_status;
  logic                   res_answer;
  logic signed [2*VW-1:0] prod;
  logic                   neg_q;
  logic                   out_free;
  logic [SP_W+6:0]        depth_ext;

  logic [2:0]             dec_status;
  logic [VW-1:0]          dec_value;
  logic                   dec_answer;
  logic                   dec_wr;
  logic [ADDR_W-1:0]      dec_addr;
  logic [SP_W-1:0]        dec_sp;
  state_t                 dec_state;

  logic signed [VW-1:0]   left_v;
  logic signed [VW-1:0]   right_v;
  logic [VW-1:0]          left_mag;
  logic [VW-1:0]          right_mag;
  logic signed [WW-1:0]   sum_w;
  logic signed [WW-1:0]   dif_w;
  logic signed [2*VW-1:0] prod_sh;
  logic signed [WW-1:0]   mul_w;
  logic signed [WW-1:0]   quo_w;
  pse_pkg::sat_res_t      sum_s;
  pse_pkg::sat_res_t      dif_s;
  pse_pkg::sat_res_t      mul_s;
  pse_pkg::sat_res_t      quo_s;

  logic                   div_start;
  pse_pkg::div_ctrl_t     div_ctrl;
  logic [pse_pkg::NUM_W-1:0] div_quo;

  function automatic pse_pkg::sat_res_t saturate(input logic signed [WW-1:0] v);
    pse_pkg::sat_res_t r;
    if (v > $signed({{(WW-VW+1){1'b0}}, {(VW-1){1'b1}}})) begin
      r.sat   = 1'b1;
      r.value = {1'b0, {(VW-1){1'b1}}};
    end else if (v < $signed({{(WW-VW+1){1'b1}}, {(VW-1){1'b0}}})) begin
      r.sat   = 1'b1;
      r.value = {1'b1, {(VW-1){1'b0}}};
    end else begin
      r.sat   = 1'b0;
      r.value = v[VW-1:0];
    end
    return r;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign mem_we   = (state == S_DONE) && out_free && wr_en;

  // The entry below the cached top is the left operand.
  assign rd_addr = ADDR_W'(sp - SP_W'(2));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= res_value;
    end
    rd_data <= mem[rd_addr];
  end

  // Operand arithmetic; left comes from memory, right is the cached top.
  assign left_v    = $signed(rd_data);
  assign right_v   = $signed(top);
  assign left_mag  = left_v[VW-1] ? (~rd_data + 1'b1) : rd_data;
  assign right_mag = right_v[VW-1] ? (~top + 1'b1) : top;
  assign sum_w     = WW'(left_v) + WW'(right_v);
  assign dif_w     = WW'(left_v) - WW'(right_v);
  assign sum_s     = saturate(sum_w);
  assign dif_s     = saturate(dif_w);

  // Arithmetic shift floors; add one back for negative products with a fraction.
  assign prod_sh = prod >>> pse_pkg::FRAC_W;
  assign mul_w   = prod_sh[WW-1:0] + WW'(prod[2*VW-1] && (prod[pse_pkg::FRAC_W-1:0] != '0));
  assign mul_s   = saturate(mul_w);

  assign quo_w = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign quo_s = saturate(quo_w);

  assign div_start = (state == S_READ) && (op_q == pse_pkg::OP_DIV) && (top != '0);

  pse_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({left_mag, {pse_pkg::FRAC_W{1'b0}}}),
    .den   (right_mag),
    .ctrl  (div_ctrl),
    .quo   (div_quo)
  );

  // Token decode for the idle state; operators that do not underflow go on to read their left operand.
  always_comb begin
    dec_status = pse_pkg::ST_OK;
    dec_answer = 1'b0;
    dec_value  = (sp != '0) ? top : '0;
    dec_wr     = 1'b0;
    dec_addr   = rd_addr;
    dec_sp     = sp;
    dec_state  = S_DONE;
    unique case (op)
      pse_pkg::OP_PUSH: begin
        if (sp >= SP_W'(STACK_DEPTH)) begin
          dec_status = pse_pkg::ST_OVER;
        end else begin
          dec_value = {operand, {pse_pkg::FRAC_W{1'b0}}};
          dec_wr    = 1'b1;
          dec_addr  = sp[ADDR_W-1:0];
          dec_sp    = sp + 1'b1;
        end
      end
      pse_pkg::OP_ADD, pse_pkg::OP_SUB, pse_pkg::OP_MUL, pse_pkg::OP_DIV: begin
        if (sp < SP_W'(2)) begin
          dec_status = pse_pkg::ST_UNDER;
        end else begin
          dec_state = S_READ;
        end
      end
      pse_pkg::OP_FINISH: begin
        if (sp == '0) begin
          dec_status = pse_pkg::ST_UNDER;
        end else begin
          dec_answer = 1'b1;
          dec_sp     = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q       <= op;
            res_status <= dec_status;
            res_answer <= dec_answer;
            res_value  <= dec_value;
            wr_en      <= dec_wr;
            wr_addr    <= dec_addr;
            new_sp     <= dec_sp;
            state      <= dec_state;
          end
        end
        S_READ: begin
          case (op_q)
            pse_pkg::OP_ADD: begin
              res_value  <= sum_s.value;
              res_status <= sum_s.sat ? pse_pkg::ST_SAT : pse_pkg::ST_OK;
              wr_en      <= 1'b1;
              new_sp     <= sp - 1'b1;
              state      <= S_DONE;
            end
            pse_pkg::OP_SUB: begin
              res_value  <= dif_s.value;
              res_status <= dif_s.sat ? pse_pkg::ST_SAT : pse_pkg::ST_OK;
              wr_en      <= 1'b1;
              new_sp     <= sp - 1'b1;
              state      <= S_DONE;
            end
            pse_pkg::OP_MUL: begin
              prod  <= left_v * right_v;
              state <= S_MUL;
            end
            default: begin
              if (top == '0) begin
                res_status <= pse_pkg::ST_DIVZERO;
                state      <= S_DONE;
              end else begin
                neg_q <= left_v[VW-1] ^ right_v[VW-1];
                state <= S_DIV;
              end
            end
          endcase
        end
        S_MUL: begin
          res_value  <= mul_s.value;
          res_status <= mul_s.sat ? pse_pkg::ST_SAT : pse_pkg::ST_OK;
          wr_en      <= 1'b1;
          new_sp     <= sp - 1'b1;
          state      <= S_DONE;
        end
        S_DIV: begin
          if (div_ctrl.done) begin
            res_value  <= quo_s.value;
            res_status <= quo_s.sat ? pse_pkg::ST_SAT : pse_pkg::ST_OK;
            wr_en      <= 1'b1;
            new_sp     <= sp - 1'b1;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          // Commit the stack update together with loading the output beat.
          if (out_free) begin
            sp    <= new_sp;
            state <= S_IDLE;
            if (wr_en) begin
              top <= res_value;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign depth_ext = {7'b0, new_sp};

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      top_value    <= $signed(res_value);
      stack_depth  <= depth_ext[6:0];
      status       <= res_status;
      answer_valid <= res_answer;
    end
  end

endmodule
